// ----- rtl/bhe_pkg.sv -----
// shared types, constants and helpers of the block hash engine
package bhe_pkg;

  typedef logic [31:0] word_t;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_HEADER = 2'd1;
  localparam logic [1:0] CMD_TRANS  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam int NUM_CHAIN  = 8;
  localparam int NUM_ROUNDS = 64;
  localparam int CNT_W      = 6;
  localparam int NIB_W      = 7;

  localparam word_t ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  typedef struct packed {
    logic             load_chain;
    logic             load_msg;
    logic             header;
    logic             round;
    logic [CNT_W-1:0] round_idx;
    logic             scan;
    logic [2:0]       scan_idx;
    logic             out_load;
  } bhe_cmd_t;

endpackage

// ----- rtl/block_hash_engine_core.sv -----
// top level of the block hash engine: controller and datapath
//
// input channel: in_valid/in_ready with command, word_0..word_7, stamp, last.
// command 0 loads the eight chaining words, 1 runs a header message built
// from nonce, block id and timestamp, 2 runs an eight-word message, 3 is
// dropped. a message runs through the rounds after its accept cycle, one
// round per cycle through the shared round logic, so no new message is
// taken until its rounds are done; a load without last or a dropped item
// returns to idle after its accept. with last set, a scan counts leading
// zero nibbles one chaining word per cycle, then the result item goes to
// the output register.
// one item is worked at a time; in_ready is high while the block is idle.
// output channel: out_valid/out_ready with hash_0..hash_7, zero_nibbles,
// meets_difficulty. the output register frees the input side, so a new item
// is taken while a result waits; if the next result is done first the block
// holds it until the receiver takes the pending one.
// config channel: cfg_valid/cfg_ready with cfg_data sets difficulty.
// reset clears the chaining words and sets difficulty to 4.
module block_hash_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] word_0,
  input  logic [31:0] word_1,
  input  logic [31:0] word_2,
  input  logic [31:0] word_3,
  input  logic [31:0] word_4,
  input  logic [31:0] word_5,
  input  logic [31:0] word_6,
  input  logic [31:0] word_7,
  input  logic [63:0] stamp,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_0,
  output logic [31:0] hash_1,
  output logic [31:0] hash_2,
  output logic [31:0] hash_3,
  output logic [31:0] hash_4,
  output logic [31:0] hash_5,
  output logic [31:0] hash_6,
  output logic [31:0] hash_7,
  output logic [6:0]  zero_nibbles,
  output logic        meets_difficulty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  import bhe_pkg::*;

  bhe_cmd_t    ctl;
  word_t [7:0] in_words;
  word_t [7:0] hash;

  assign cfg_ready = 1'b1;
  assign in_words  = {word_7, word_6, word_5, word_4, word_3, word_2, word_1, word_0};

  assign hash_0 = hash[0];
  assign hash_1 = hash[1];
  assign hash_2 = hash[2];
  assign hash_3 = hash[3];
  assign hash_4 = hash[4];
  assign hash_5 = hash[5];
  assign hash_6 = hash[6];
  assign hash_7 = hash[7];

  bhe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  bhe_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .in_words         (in_words),
    .stamp            (stamp),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .hash             (hash),
    .zero_nibbles     (zero_nibbles),
    .meets_difficulty (meets_difficulty)
  );

endmodule

// ----- rtl/bhe_ctrl.sv -----
// controller: sequences capture, rounds, nibble scan and result handoff
module bhe_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      command,
  input  logic            last,
  output logic            out_valid,
  input  logic            out_ready,
  output bhe_pkg::bhe_cmd_t ctl
);
  import bhe_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             last_flag, last_flag_next;
  logic             out_valid_next;
  logic             accept;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    last_flag_next = last_flag;
    out_valid_next = out_valid && !out_ready;
    ctl            = '0;
    ctl.round_idx  = cnt;
    ctl.scan_idx   = cnt[2:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          last_flag_next = last;
          cnt_next       = '0;
          unique case (command)
            CMD_LOAD: begin
              ctl.load_chain = 1'b1;
              state_next     = last ? S_SCAN : S_IDLE;
            end
            CMD_HEADER, CMD_TRANS: begin
              ctl.load_msg = 1'b1;
              ctl.header   = (command == CMD_HEADER);
              state_next   = S_ROUND;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ROUND: begin
        ctl.round = 1'b1;
        if (cnt == CNT_W'(NUM_ROUNDS - 1)) begin
          cnt_next   = '0;
          state_next = last_flag ? S_SCAN : S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (cnt[2:0] == 3'(NUM_CHAIN - 1)) begin
          cnt_next   = '0;
          state_next = S_OUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ctl.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      last_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      last_flag <= last_flag_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/bhe_datapath.sv -----
// datapath: chaining words, message schedule, round logic, zero scan, result registers
module bhe_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  bhe_pkg::bhe_cmd_t     ctl,
  input  bhe_pkg::word_t [7:0]  in_words,
  input  logic [63:0]           stamp,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_data,
  output bhe_pkg::word_t [7:0]  hash,
  output logic [6:0]            zero_nibbles,
  output logic                  meets_difficulty
);
  import bhe_pkg::*;

  function automatic word_t rotl(input word_t x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [3:0] lead_nibbles(input word_t x);
    logic [3:0] n;
    logic       done;
    n    = '0;
    done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!done && x[31-4*i -: 4] == 4'd0) begin
        n = n + 1'b1;
      end else begin
        done = 1'b1;
      end
    end
    lead_nibbles = n;
  endfunction

  word_t [7:0]      chain, chain_next;
  word_t [3:0]      win;
  word_t [7:0]      msg;
  logic [32:0]      stamp_sum;
  logic             header;
  logic [6:0]       difficulty;
  logic [NIB_W-1:0] zeros, zeros_next;
  logic             scanning, scanning_next;

  word_t       hi_fold, lo_fold, lo_part, msg_word, w;
  word_t       a, b, c, d, e, f, g, h, m, k, t, scan_word;
  logic        from_msg;
  logic [3:0]  lz;

  assign hi_fold = (stamp[63:32] == 32'hFFFFFFFF) ? 32'd0 : stamp[63:32];
  assign lo_part = stamp_sum[32] ? (stamp_sum[31:0] + 32'd1) : stamp_sum[31:0];
  assign lo_fold = (lo_part == 32'hFFFFFFFF) ? 32'd0 : lo_part;

  always_comb begin
    from_msg = header ? (ctl.round_idx < CNT_W'(4)) : (ctl.round_idx < CNT_W'(8));
    msg_word = (header && ctl.round_idx[2:0] == 3'd2) ? lo_fold : msg[ctl.round_idx[2:0]];
    w        = from_msg ? msg_word : rotl(win[2] ^ win[0], 3);
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    unique case (ctl.round_idx[5:4])
      2'd0:    m = (b & c) | (~b & d) | (b & ~e) | (~b & ~f) | (b & ~g) | (~b & h);
      2'd2:    m = (b & c) | (b & d) | (b & e) | (b & f) | (b & g) | (b & h);
      default: m = b ^ c ^ d ^ e ^ f ^ g ^ h;
    endcase
    k = ROUND_K[ctl.round_idx[5:4]];
    t = rotl(a, 5) ^ (m & k) ^ w;
    chain_next[0] = chain[0] ^ t;
    chain_next[1] = chain[1] ^ a;
    chain_next[2] = chain[2] ^ rotl(b, 13);
    chain_next[3] = chain[3] ^ c;
    chain_next[4] = chain[4] ^ d;
    chain_next[5] = chain[5] ^ e;
    chain_next[6] = chain[6] ^ rotl(f, 29);
    chain_next[7] = chain[7] ^ g;
  end

  always_comb begin
    scan_word = chain[ctl.scan_idx];
    lz        = lead_nibbles(scan_word);
    if (ctl.scan_idx == 3'd0) begin
      zeros_next    = NIB_W'(lz);
      scanning_next = (lz == 4'd8);
    end else if (scanning) begin
      zeros_next    = zeros + NIB_W'(lz);
      scanning_next = (lz == 4'd8);
    end else begin
      zeros_next    = zeros;
      scanning_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain      <= '0;
      win        <= '0;
      difficulty <= 7'd4;
    end else begin
      if (cfg_we) begin
        difficulty <= cfg_data;
      end
      if (ctl.load_chain) begin
        chain <= in_words;
      end else if (ctl.round) begin
        chain <= chain_next;
        win   <= {w, win[3], win[2], win[1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_msg) begin
      header    <= ctl.header;
      stamp_sum <= {1'b0, stamp[63:32]} + {1'b0, stamp[31:0]};
      if (ctl.header) begin
        msg <= {in_words[7:4], in_words[1], in_words[2], hi_fold, in_words[0]};
      end else begin
        msg <= in_words;
      end
    end
    if (ctl.scan) begin
      zeros    <= zeros_next;
      scanning <= scanning_next;
    end
    if (ctl.out_load) begin
      hash             <= chain;
      zero_nibbles     <= zeros;
      meets_difficulty <= (zeros == difficulty);
    end
  end

endmodule

// ----- tb/block_hash_engine_checker.sv -----
// checker for the block hash engine: predicts each digest and compares the output channel
module block_hash_engine_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] word_0,
  input  logic [31:0] word_1,
  input  logic [31:0] word_2,
  input  logic [31:0] word_3,
  input  logic [31:0] word_4,
  input  logic [31:0] word_5,
  input  logic [31:0] word_6,
  input  logic [31:0] word_7,
  input  logic [63:0] stamp,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] hash_0,
  input  logic [31:0] hash_1,
  input  logic [31:0] hash_2,
  input  logic [31:0] hash_3,
  input  logic [31:0] hash_4,
  input  logic [31:0] hash_5,
  input  logic [31:0] hash_6,
  input  logic [31:0] hash_7,
  input  logic [6:0]  zero_nibbles,
  input  logic        meets_difficulty,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import bhe_pkg::*;

  typedef struct packed {
    word_t [NUM_CHAIN-1:0] hash;
    logic [NIB_W-1:0]      zeros;
    logic                  meets;
  } digest_t;

  word_t            chain [NUM_CHAIN];
  word_t            window [4];
  logic [NIB_W-1:0] difficulty;
  digest_t          digests [$];
  int               fails = 0;
  int               results = 0;

  function automatic word_t rotl(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void run_rounds(input word_t msg [NUM_CHAIN], input int len);
    word_t w, m, k, t;
    word_t v [NUM_CHAIN];
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      if (r < len) w = msg[r];
      else w = rotl(window[2] ^ window[0], 3);
      window[0] = window[1];
      window[1] = window[2];
      window[2] = window[3];
      window[3] = w;
      v = chain;
      if (r < 16) begin
        m = (v[1] & v[2]) | (~v[1] & v[3]) | (v[1] & ~v[4]) | (~v[1] & ~v[5]) |
            (v[1] & ~v[6]) | (~v[1] & v[7]);
        k = ROUND_K[0];
      end else if (r < 32) begin
        m = v[1] ^ v[2] ^ v[3] ^ v[4] ^ v[5] ^ v[6] ^ v[7];
        k = ROUND_K[1];
      end else if (r < 48) begin
        m = v[1] & (v[2] | v[3] | v[4] | v[5] | v[6] | v[7]);
        k = ROUND_K[2];
      end else begin
        m = v[1] ^ v[2] ^ v[3] ^ v[4] ^ v[5] ^ v[6] ^ v[7];
        k = ROUND_K[3];
      end
      t = rotl(v[0], 5) ^ (m & k) ^ w;
      chain[0] ^= t;
      chain[1] ^= v[0];
      chain[2] ^= rotl(v[1], 13);
      chain[3] ^= v[2];
      chain[4] ^= v[3];
      chain[5] ^= v[4];
      chain[6] ^= rotl(v[5], 29);
      chain[7] ^= v[6];
    end
  endfunction

  function automatic void absorb_item();
    word_t       words [NUM_CHAIN];
    word_t       msg [NUM_CHAIN];
    logic [63:0] folded;
    digest_t     d;
    int          zeros;
    bit          scanning;
    words = '{word_0, word_1, word_2, word_3, word_4, word_5, word_6, word_7};
    if (command == CMD_NONE) return;
    case (command)
      CMD_LOAD: chain = words;
      CMD_HEADER: begin
        msg = '{default: '0};
        folded = stamp % 64'h0000_0000_FFFF_FFFF;
        msg[0] = word_0;
        msg[1] = (stamp[63:32] == 32'hFFFF_FFFF) ? 32'h0 : stamp[63:32];
        msg[2] = folded[31:0];
        msg[3] = word_1;
        run_rounds(msg, 4);
      end
      default: run_rounds(words, NUM_CHAIN);
    endcase
    if (!last) return;
    zeros = 0;
    scanning = 1'b1;
    for (int i = 0; i < NUM_CHAIN * 8; i++) begin
      if (scanning) begin
        if (chain[i / 8][31 - 4 * (i % 8) -: 4] == 4'h0) zeros++;
        else scanning = 1'b0;
      end
    end
    for (int i = 0; i < NUM_CHAIN; i++) d.hash[i] = chain[i];
    d.zeros = NIB_W'(zeros);
    d.meets = (zeros == int'(difficulty));
    digests.push_back(d);
  endfunction

  function automatic void compare(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fails++;
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    digest_t want;
    word_t   got [NUM_CHAIN];
    if (rst) begin
      chain = '{default: '0};
      window = '{default: '0};
      difficulty = 7'd4;
      digests.delete();
    end else begin
      if (cfg_valid && cfg_ready) difficulty = cfg_data;
      if (out_valid && out_ready) begin
        results++;
        if (digests.size() == 0) begin
          fails++;
          $error("result item arrived with none expected");
        end else begin
          want = digests.pop_front();
          got = '{hash_0, hash_1, hash_2, hash_3, hash_4, hash_5, hash_6, hash_7};
          for (int i = 0; i < NUM_CHAIN; i++)
            compare($sformatf("hash_%0d", i), want.hash[i], got[i]);
          compare("zero_nibbles", 32'(want.zeros), 32'(zero_nibbles));
          compare("meets_difficulty", 32'(want.meets), 32'(meets_difficulty));
        end
      end
      if (in_valid && in_ready) absorb_item();
    end
    fail_count <= fails;
    pending_count <= digests.size();
    result_count <= results;
  end

endmodule

// ----- tb/block_hash_engine_core_tb.sv -----
// testbench top for the block hash engine: stimulus, receiver stalls, watchdog and verdict
module block_hash_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bhe_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int NUM_PHASES    = 6;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [31:0] word_0, word_1, word_2, word_3, word_4, word_5, word_6, word_7;
  logic [63:0] stamp;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] hash_0, hash_1, hash_2, hash_3, hash_4, hash_5, hash_6, hash_7;
  logic [6:0]  zero_nibbles;
  logic        meets_difficulty;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;

  int fail_count;
  int pending_count;
  int result_count;

  bit         offering = 1'b0;
  bit         steady = 1'b0;
  bit         hold_go = 1'b0;
  int         items_sent = 0;
  int         cfg_writes = 0;
  int         stuck = 0;
  logic [6:0] cur_difficulty = 7'd4;

  block_hash_engine_core u_top (.*);

  block_hash_engine_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic offer(input logic [1:0] cmd, input word_t w [NUM_CHAIN],
                       input logic [63:0] ts, input logic lst);
    command <= cmd;
    word_0 <= w[0];
    word_1 <= w[1];
    word_2 <= w[2];
    word_3 <= w[3];
    word_4 <= w[4];
    word_5 <= w[5];
    word_6 <= w[6];
    word_7 <= w[7];
    stamp <= ts;
    last <= lst;
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (cmd != CMD_NONE) items_sent++;
    if (!steady && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_difficulty(input logic [6:0] value);
    quiesce();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_difficulty = value;
    cfg_writes++;
  endtask

  function automatic void rand_words(output word_t w [NUM_CHAIN]);
    for (int i = 0; i < NUM_CHAIN; i++) w[i] = $urandom;
  endfunction

  // chaining words with exactly the given count of leading zero nibbles
  function automatic void zeros_words(output word_t w [NUM_CHAIN], input int target);
    logic [255:0] v;
    for (int i = 0; i < NUM_CHAIN; i++) v[32 * i +: 32] = $urandom;
    if (target >= 64) begin
      v = '0;
    end else begin
      v = v >> (4 * target);
      v[252 - 4 * target] = 1'b1;
    end
    for (int i = 0; i < NUM_CHAIN; i++) w[i] = v[255 - 32 * i -: 32];
  endfunction

  function automatic logic [63:0] rand_stamp();
    return {$urandom, $urandom};
  endfunction

  task automatic random_sequence();
    word_t w [NUM_CHAIN];
    int    n;
    int    target;
    logic  [1:0] cmd;
    if ($urandom_range(0, 99) < 85) begin
      if (cur_difficulty <= 64 && $urandom_range(0, 99) < 40) target = cur_difficulty;
      else target = $urandom_range(0, 64);
      zeros_words(w, target);
      offer(CMD_LOAD, w, rand_stamp(), $urandom_range(0, 99) < 30);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        rand_words(w);
        cmd = $urandom_range(0, 1) ? CMD_HEADER : CMD_TRANS;
        offer(cmd, w, rand_stamp(), (i == n - 1) || ($urandom_range(0, 99) < 20));
      end
    end else begin
      rand_words(w);
      offer(2'($urandom_range(0, 3)), w, rand_stamp(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    word_t      zero_w [NUM_CHAIN];
    word_t      ones_w [NUM_CHAIN];
    word_t      w [NUM_CHAIN];
    logic [6:0] phase_difficulty [NUM_PHASES];
    int         goal;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_LOAD;
    {word_0, word_1, word_2, word_3} = '0;
    {word_4, word_5, word_6, word_7} = '0;
    stamp = '0;
    last = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    zero_w = '{default: 32'h0};
    ones_w = '{default: 32'hFFFF_FFFF};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed items
    offer(CMD_LOAD, zero_w, 64'h0, 1'b1);
    offer(CMD_LOAD, ones_w, '1, 1'b1);
    zeros_words(w, 4);
    offer(CMD_LOAD, w, 64'h0, 1'b1);
    offer(CMD_HEADER, ones_w, '1, 1'b1);
    rand_words(w);
    offer(CMD_HEADER, w, {32'hFFFF_FFFF, $urandom}, 1'b1);
    rand_words(w);
    offer(CMD_HEADER, w, 64'h0000_0000_FFFF_FFFF, 1'b0);
    offer(CMD_HEADER, zero_w, 64'h0, 1'b1);
    offer(CMD_TRANS, ones_w, '1, 1'b0);
    offer(CMD_TRANS, zero_w, 64'h0, 1'b1);
    rand_words(w);
    offer(CMD_NONE, w, rand_stamp(), 1'b1);
    offer(CMD_NONE, ones_w, '1, 1'b0);
    rand_words(w);
    offer(CMD_TRANS, w, rand_stamp(), 1'b1);
    offer(CMD_LOAD, zero_w, 64'h0, 1'b0);
    rand_words(w);
    offer(CMD_HEADER, w, rand_stamp(), 1'b0);
    rand_words(w);
    offer(CMD_TRANS, w, rand_stamp(), 1'b1);
    write_difficulty(7'd64);
    offer(CMD_LOAD, zero_w, 64'h0, 1'b1);
    zeros_words(w, 63);
    offer(CMD_LOAD, w, 64'h0, 1'b1);
    write_difficulty(7'd0);
    offer(CMD_LOAD, ones_w, 64'h0, 1'b1);
    write_difficulty(7'd127);
    offer(CMD_LOAD, zero_w, 64'h0, 1'b1);
    zeros_words(w, 0);
    offer(CMD_LOAD, w, 64'h0, 1'b1);

    // random phases, each under its own difficulty
    phase_difficulty[0] = 7'($urandom_range(1, 63));
    phase_difficulty[1] = 7'd4;
    phase_difficulty[2] = 7'd0;
    phase_difficulty[3] = 7'd64;
    phase_difficulty[4] = 7'd65;
    phase_difficulty[5] = 7'($urandom_range(0, 127));
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_difficulty(phase_difficulty[p]);
      steady = (p == 2);
      if (p == 1) hold_go = 1'b1;
      goal = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < goal) random_sequence();
    end
    steady = 1'b0;

    quiesce();
    $display("%0d items accepted (ignored commands not counted), %0d digests checked",
             items_sent, result_count);
    $display("%0d difficulty writes, %0d mismatches", cfg_writes, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bhe_pkg.sv
rtl/bhe_ctrl.sv
rtl/bhe_datapath.sv
rtl/block_hash_engine_core.sv
tb/block_hash_engine_checker.sv
tb/block_hash_engine_core_tb.sv
